FILE: rtl/dprq_pkg.sv
// Package with the shared types and constants of the delimited packet receive queue.
`timescale 1ns / 1ps

package dprq_pkg;

  localparam int unsigned QUEUE_WORDS = 64;
  localparam int unsigned RING_BYTES  = 2 * QUEUE_WORDS;
  localparam int unsigned IDX_W       = $clog2(RING_BYTES);
  localparam int unsigned CNT_W       = $clog2(RING_BYTES + 1);
  localparam int unsigned POS_W       = 9;
  localparam int unsigned PKT_W       = 8;
  localparam int unsigned OVF_W       = 32;
  localparam int unsigned DATA_W      = 16;

  localparam logic [DATA_W-1:0] EMPTY_CODE    = 16'hFF00;
  localparam logic [POS_W-1:0]  MAX_PKT_RESET = 9'd128;
  localparam logic [POS_W-1:0]  POS_MAX       = '1;
  localparam logic [PKT_W-1:0]  PKT_MAX       = '1;
  localparam logic [OVF_W-1:0]  OVF_MAX       = '1;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP_RAW = 2'd1,
    CMD_POP_PKT = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] ridx;
    logic [IDX_W-1:0] widx;
    logic [CNT_W-1:0] bcnt;
    logic [PKT_W-1:0] pcnt;
    logic [OVF_W-1:0] ovf;
    logic [POS_W-1:0] pos;
  } q_state_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } mem_wr_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              data_valid;
    logic              end_of_packet;
    logic              flushed;
    logic              packet_too_long;
    logic              no_packet;
  } result_t;

endpackage

FILE: rtl/dprq_byte_ring.sv
// Byte ring storage with one write port and one registered read port with write bypass.
`timescale 1ns / 1ps

module dprq_byte_ring
  import dprq_pkg::*;
(
  input  logic             clk,
  input  mem_wr_t          wr,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [7:0]       rd_data_r
);

  logic [7:0] mem [RING_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // A byte written in the same cycle as it is read comes straight through.
  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == rd_addr)) begin
      rd_data_r <= wr.data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/dprq_step.sv
// Combinational update of the queue state and the result for one command.
`timescale 1ns / 1ps

module dprq_step
  import dprq_pkg::*;
(
  input  q_state_t         st,
  input  cmd_t             cmd,
  input  logic [7:0]       rx_byte,
  input  logic             link_overrun,
  input  logic [7:0]       head_byte,
  input  logic [POS_W-1:0] max_packet_bytes,
  output q_state_t         st_nxt,
  output result_t          res,
  output mem_wr_t          wr
);

  logic             empty;
  logic             full;
  logic [IDX_W-1:0] ridx_inc;
  logic [IDX_W-1:0] widx_inc;
  logic [POS_W-1:0] pos_inc;

  assign empty    = (st.bcnt == '0);
  assign full     = (st.bcnt >= CNT_W'(RING_BYTES));
  assign ridx_inc = (st.ridx == IDX_W'(RING_BYTES - 1)) ? '0 : st.ridx + 1'b1;
  assign widx_inc = (st.widx == IDX_W'(RING_BYTES - 1)) ? '0 : st.widx + 1'b1;
  assign pos_inc  = (st.pos == POS_MAX) ? st.pos : st.pos + 1'b1;

  always_comb begin
    st_nxt  = st;
    res     = '0;
    wr.en   = 1'b0;
    wr.addr = st.widx;
    wr.data = rx_byte;
    unique case (cmd)
      CMD_PUSH: begin
        if (full || link_overrun) begin
          st_nxt.ridx = '0;
          st_nxt.widx = '0;
          st_nxt.bcnt = '0;
          st_nxt.pcnt = '0;
          st_nxt.pos  = '0;
          if (st.ovf != OVF_MAX) begin
            st_nxt.ovf = st.ovf + 1'b1;
          end
          res.flushed = 1'b1;
        end else begin
          wr.en       = 1'b1;
          st_nxt.widx = widx_inc;
          st_nxt.bcnt = st.bcnt + 1'b1;
          if ((rx_byte == 8'd0) && (st.pcnt != PKT_MAX)) begin
            st_nxt.pcnt = st.pcnt + 1'b1;
          end
        end
      end
      CMD_POP_RAW: begin
        if (!empty) begin
          res.data       = DATA_W'(head_byte);
          res.data_valid = 1'b1;
          st_nxt.ridx    = ridx_inc;
          st_nxt.bcnt    = st.bcnt - 1'b1;
        end else begin
          res.data = EMPTY_CODE;
        end
      end
      CMD_POP_PKT: begin
        if (st.pcnt == '0) begin
          res.no_packet = 1'b1;
        end else if (!empty) begin
          res.data            = DATA_W'(head_byte);
          res.data_valid      = 1'b1;
          res.packet_too_long = (pos_inc >= max_packet_bytes);
          st_nxt.ridx         = ridx_inc;
          st_nxt.bcnt         = st.bcnt - 1'b1;
          st_nxt.pos          = pos_inc;
          if (head_byte == 8'd0) begin
            res.end_of_packet = 1'b1;
            st_nxt.pcnt       = st.pcnt - 1'b1;
            st_nxt.pos        = '0;
          end
        end else begin
          res.data = EMPTY_CODE;
        end
      end
      CMD_NOP: begin
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/delimited_packet_rx_queue.sv
// Top level of the receive byte queue with a count of zero-delimited packets.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_ready  cmd, rx_byte, link_overrun
// out_      output     out_valid/out_ready data, flags, packets, bytes, overflow total
// cfg_      input      cfg_valid/cfg_ready max_packet_bytes (9 bits)
//
// A command passes through the input register and then the output register: the
// step logic works on it while it sits in the input register, and the result then
// waits in the output register for its own transfer.
// One command can be taken every cycle while the output is not stalled; the state
// update and the ring read port together set that figure.
// Reset clears the queue state and the overflow counter and sets the length limit to 128.
// The ring contents are not cleared; only queued bytes are ever read.
// A stall on the output holds the command in the input register, and in_ready stays low meanwhile.

module delimited_packet_rx_queue
  import dprq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  input  logic [7:0]        in_rx_byte,
  input  logic              in_link_overrun,

  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_data,
  output logic              out_data_valid,
  output logic              out_end_of_packet,
  output logic              out_flushed,
  output logic              out_packet_too_long,
  output logic              out_no_packet,
  output logic [7:0]        out_packets_waiting,
  output logic [7:0]        out_bytes_queued,
  output logic [31:0]       out_overflow_total,

  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [8:0]        cfg_data
);

  // Input register holding the command that is being worked on.
  logic             s1_valid_r;
  logic [1:0]       cmd_r;
  logic [7:0]       rx_byte_r;
  logic             link_overrun_r;

  // Architectural queue state and the length limit register.
  q_state_t         st_r;
  q_state_t         st_nxt;
  logic [POS_W-1:0] max_pkt_r;

  // Output register.
  logic             out_valid_r;
  result_t          res_r;
  logic [PKT_W-1:0] pkts_r;
  logic [7:0]       bytes_r;
  logic [OVF_W-1:0] ovf_r;

  result_t          res_nxt;
  mem_wr_t          step_wr;
  mem_wr_t          ring_wr;
  logic [7:0]       head_byte;
  logic [IDX_W-1:0] rd_addr;
  logic             fire;

  // The command in the input register retires when the output register is free
  // or is being emptied in the same cycle.
  assign fire      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r          <= in_cmd;
      rx_byte_r      <= in_rx_byte;
      link_overrun_r <= in_link_overrun;
    end
  end

  dprq_step u_step (
    .st               (st_r),
    .cmd              (cmd_t'(cmd_r)),
    .rx_byte          (rx_byte_r),
    .link_overrun     (link_overrun_r),
    .head_byte        (head_byte),
    .max_packet_bytes (max_pkt_r),
    .st_nxt           (st_nxt),
    .res              (res_nxt),
    .wr               (step_wr)
  );

  // The ring is only written when the command really retires.
  always_comb begin
    ring_wr    = step_wr;
    ring_wr.en = step_wr.en && fire;
  end

  // The read port always fetches the byte at the read index that holds after
  // this cycle, so the head byte is ready for whatever command comes next.
  assign rd_addr = fire ? st_nxt.ridx : st_r.ridx;

  dprq_byte_ring u_ring (
    .clk       (clk),
    .wr        (ring_wr),
    .rd_addr   (rd_addr),
    .rd_data_r (head_byte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pkt_r <= MAX_PKT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_pkt_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r   <= res_nxt;
      pkts_r  <= st_nxt.pcnt;
      bytes_r <= 8'(st_nxt.bcnt);
      ovf_r   <= st_nxt.ovf;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_data            = res_r.data;
  assign out_data_valid      = res_r.data_valid;
  assign out_end_of_packet   = res_r.end_of_packet;
  assign out_flushed         = res_r.flushed;
  assign out_packet_too_long = res_r.packet_too_long;
  assign out_no_packet       = res_r.no_packet;
  assign out_packets_waiting = pkts_r;
  assign out_bytes_queued    = bytes_r;
  assign out_overflow_total  = ovf_r;

  // Write index always sits byte_count places after the read index.
  logic [IDX_W:0] idx_sum;
  logic [IDX_W:0] idx_wrap;

  assign idx_sum  = (IDX_W + 1)'(st_r.ridx) + (IDX_W + 1)'(st_r.bcnt);
  assign idx_wrap = (idx_sum >= (IDX_W + 1)'(RING_BYTES)) ?
                    idx_sum - (IDX_W + 1)'(RING_BYTES) : idx_sum;

  a_ring_indices: assert property (@(posedge clk) disable iff (!rst_n)
    idx_wrap[IDX_W-1:0] == st_r.widx)
    else $error("ring write index out of step with read index and byte count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.bcnt <= CNT_W'(RING_BYTES))
    else $error("byte count above ring size");

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_nxt.flushed |=> (st_r.bcnt == '0) && (st_r.pcnt == '0) && (st_r.pos == '0))
    else $error("flush did not empty the queue");

  a_popped_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.data_valid |-> (res_r.data[15:8] == 8'd0) && !res_r.flushed)
    else $error("popped result carries more than a byte");

endmodule
